### sv/sfcs_pkg.sv
// Types and codes shared by the serial flash command sequencer modules.
package sfcs_pkg;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_WREN     = 3'd1,
    PH_CHECK    = 3'd2,
    PH_CMD      = 3'd3,
    PH_READING  = 3'd4,
    PH_WAITBUSY = 3'd5,
    PH_ERROR    = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_READ  = 2'd1,
    OP_PROG  = 2'd2,
    OP_ERASE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_WREN    = 3'd1,
    CMD_RDSR    = 3'd2,
    CMD_READ    = 3'd3,
    CMD_PROGRAM = 3'd4,
    CMD_ERASE   = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    FLT_NONE    = 2'd0,
    FLT_WEL     = 2'd1,
    FLT_TIMEOUT = 2'd2
  } fault_e;

  typedef enum logic {
    REG_RETRY_LIMIT   = 1'b0,
    REG_TIMEOUT_LIMIT = 1'b1
  } reg_idx_e;

  localparam int unsigned CfgWidth = 32;

  localparam logic [7:0]  RetryLimitRst   = 8'd3;
  localparam logic [31:0] TimeoutLimitRst = 32'd1000000;

  localparam int unsigned StatusBusyBit = 0;
  localparam int unsigned StatusWelBit  = 1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [23:0] flash_addr;
    logic [15:0] byte_count;
    logic [7:0]  status_byte;
  } sfcs_in_t;

  typedef struct packed {
    logic        accepted;
    logic [2:0]  command;
    logic [23:0] cmd_addr;
    logic [15:0] cmd_len;
    logic        done_res;
    logic        success;
    logic [1:0]  fault;
    logic [2:0]  phase;
  } sfcs_out_t;

endpackage

### sv/sfcs_in_stage.sv
// Input register stage: holds one accepted item until the core takes it.
module sfcs_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sfcs_pkg::sfcs_in_t in_data_i,
  input  logic             room_i,
  output logic             step_o,
  output sfcs_pkg::sfcs_in_t item_o
);
  import sfcs_pkg::*;

  logic     valid_q, valid_d;
  sfcs_in_t data_q;
  logic     load;

  assign step_o     = valid_q && room_i;
  assign in_ready_o = !valid_q || room_i;
  assign load       = in_valid_i && in_ready_o;
  assign item_o     = data_q;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (step_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= in_data_i;
    end
  end

endmodule

### sv/sfcs_core.sv
// Sequencer state, configuration registers and the per-item step logic.
module sfcs_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  sfcs_pkg::sfcs_in_t   item_i,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [sfcs_pkg::CfgWidth-1:0] cfg_wdata_i,
  output sfcs_pkg::sfcs_out_t  res_o
);
  import sfcs_pkg::*;

  phase_e      phase_q, phase_d;
  op_e         op_q, op_d;
  fault_e      fault_q, fault_d;
  logic [23:0] addr_q, addr_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  retry_q, retry_d;
  logic [31:0] wait_q, wait_d;
  logic [7:0]  retry_limit_q;
  logic [31:0] timeout_limit_q;

  logic        is_start, wel, busy;
  logic [7:0]  retry_inc;
  logic [31:0] wait_inc;
  logic        retry_fail, wait_fail;

  assign is_start   = (item_i.opcode != OP_NONE);
  assign wel        = item_i.status_byte[StatusWelBit];
  assign busy       = item_i.status_byte[StatusBusyBit];
  // saturate both counters
  assign retry_inc  = (retry_q != 8'hFF) ? retry_q + 8'd1 : retry_q;
  assign wait_inc   = (wait_q != 32'hFFFF_FFFF) ? wait_q + 32'd1 : wait_q;
  assign retry_fail = (retry_inc >= retry_limit_q);
  assign wait_fail  = (wait_inc >= timeout_limit_q);

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (step_i) begin
      if (is_start) begin
        if (phase_q == PH_IDLE) begin
          phase_d = (item_i.opcode == OP_READ) ? PH_CMD : PH_WREN;
        end
      end else begin
        case (phase_q)
          PH_IDLE:     phase_d = PH_IDLE;
          PH_WREN:     phase_d = PH_CHECK;
          PH_CHECK: begin
            if (wel) begin
              phase_d = PH_CMD;
            end else if (retry_fail) begin
              phase_d = PH_ERROR;
            end else begin
              phase_d = PH_WREN;
            end
          end
          PH_CMD: begin
            if (op_q == OP_READ) begin
              phase_d = PH_READING;
            end else if (op_q == OP_PROG || op_q == OP_ERASE) begin
              phase_d = PH_WAITBUSY;
            end else begin
              phase_d = PH_IDLE;
            end
          end
          PH_READING:  phase_d = PH_IDLE;
          PH_WAITBUSY: begin
            if (!busy) begin
              phase_d = PH_IDLE;
            end else if (wait_fail) begin
              phase_d = PH_ERROR;
            end
          end
          PH_ERROR:    phase_d = PH_IDLE;
          default:     phase_d = PH_IDLE;
        endcase
      end
    end
  end

  // result fields and data state
  always_comb begin
    op_d    = op_q;
    fault_d = fault_q;
    addr_d  = addr_q;
    len_d   = len_q;
    retry_d = retry_q;
    wait_d  = wait_q;

    res_o          = '0;
    res_o.command  = CMD_NONE;
    res_o.fault    = FLT_NONE;
    res_o.phase    = phase_d;

    if (step_i) begin
      if (is_start) begin
        if (phase_q == PH_IDLE) begin
          res_o.accepted = 1'b1;
          op_d    = op_e'(item_i.opcode);
          addr_d  = item_i.flash_addr;
          len_d   = (item_i.opcode == OP_ERASE) ? 16'd0 : item_i.byte_count;
          retry_d = '0;
          wait_d  = '0;
          fault_d = FLT_NONE;
        end
      end else begin
        case (phase_q)
          PH_IDLE: ;
          PH_WREN: begin
            res_o.command = CMD_WREN;
            wait_d        = '0;
          end
          PH_CHECK: begin
            res_o.command = CMD_RDSR;
            if (wel) begin
              wait_d = '0;
            end else begin
              retry_d = retry_inc;
              if (retry_fail) begin
                fault_d = FLT_WEL;
              end
            end
          end
          PH_CMD: begin
            if (op_q == OP_READ || op_q == OP_PROG || op_q == OP_ERASE) begin
              res_o.cmd_addr = addr_q;
              res_o.cmd_len  = len_q;
              case (op_q)
                OP_READ:  res_o.command = CMD_READ;
                OP_PROG:  res_o.command = CMD_PROGRAM;
                default:  res_o.command = CMD_ERASE;
              endcase
              if (op_q != OP_READ) begin
                wait_d = '0;
              end
            end else begin
              wait_d  = '0;
              retry_d = '0;
              op_d    = OP_NONE;
            end
          end
          PH_READING: begin
            res_o.done_res = 1'b1;
            res_o.success  = 1'b1;
          end
          PH_WAITBUSY: begin
            res_o.command = CMD_RDSR;
            if (!busy) begin
              res_o.done_res = 1'b1;
              res_o.success  = 1'b1;
            end else begin
              wait_d = wait_inc;
              if (wait_fail) begin
                fault_d = FLT_TIMEOUT;
              end
            end
          end
          PH_ERROR: begin
            res_o.done_res = 1'b1;
            res_o.fault    = fault_q;
            wait_d         = '0;
            retry_d        = '0;
            op_d           = OP_NONE;
          end
          default: begin
            wait_d  = '0;
            retry_d = '0;
            op_d    = OP_NONE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      op_q    <= OP_NONE;
      fault_q <= FLT_NONE;
      addr_q  <= '0;
      len_q   <= '0;
      retry_q <= '0;
      wait_q  <= '0;
    end else begin
      phase_q <= phase_d;
      op_q    <= op_d;
      fault_q <= fault_d;
      addr_q  <= addr_d;
      len_q   <= len_d;
      retry_q <= retry_d;
      wait_q  <= wait_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_limit_q   <= RetryLimitRst;
      timeout_limit_q <= TimeoutLimitRst;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_RETRY_LIMIT:   retry_limit_q   <= cfg_wdata_i[7:0];
        REG_TIMEOUT_LIMIT: timeout_limit_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  a_accept_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.accepted |-> phase_q == PH_IDLE)
    else $error("start taken outside idle");

  a_done_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.done_res |=> phase_q == PH_IDLE)
    else $error("finished item did not return to idle");

  a_fault_only_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.fault != FLT_NONE |-> res_o.done_res && !res_o.success)
    else $error("fault reported without a failing finish");

  a_error_has_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_ERROR |-> fault_q != FLT_NONE)
    else $error("error phase without fault code");

endmodule

### sv/sfcs_out_stage.sv
// Result register: holds one result item until the consumer takes it.
module sfcs_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  sfcs_pkg::sfcs_out_t res_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sfcs_pkg::sfcs_out_t out_data_o
);
  import sfcs_pkg::*;

  logic      valid_q, valid_d;
  sfcs_out_t data_q;

  assign room_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_comb begin
    valid_d = valid_q;
    if (step_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      data_q <= res_i;
    end
  end

endmodule

### sv/spi_flash_command_sequencer.sv
// Serial NOR flash command sequencer: one result item per input item, one item
// per cycle sustained while out_ready_i holds high. An item is registered in the
// input register on entry, stepped through the sequencer state once the result
// register has room and then held in the result register until taken; the
// single state update per item sets the one-per-cycle rate. Configuration writes take
// effect at the clock edge of the write and should be made while no item is in
// flight.
module spi_flash_command_sequencer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  sfcs_pkg::sfcs_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sfcs_pkg::sfcs_out_t  out_data_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [sfcs_pkg::CfgWidth-1:0] cfg_wdata_i
);
  import sfcs_pkg::*;

  logic      room, step;
  sfcs_in_t  item;
  sfcs_out_t res;

  sfcs_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .room_i     (room),
    .step_o     (step),
    .item_o     (item)
  );

  sfcs_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (item),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_o       (res)
  );

  sfcs_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .res_i       (res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

### verif/testbench.sv
// Self-checking testbench for the serial flash command sequencer.
`timescale 1ns / 100ps

module testbench;
  import sfcs_pkg::*;

  localparam int unsigned RandomItems   = 840;
  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned MaxReports    = 20;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  sfcs_in_t            in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  sfcs_out_t           out_data_o;
  logic                cfg_we_i;
  logic                cfg_idx_i;
  logic [CfgWidth-1:0] cfg_wdata_i;

  spi_flash_command_sequencer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Sequencer state as predicted from the accepted items
  phase_e      seq_phase;
  op_e         seq_op;
  logic [23:0] seq_addr;
  logic [15:0] seq_len;
  logic [7:0]  seq_retries;
  logic [31:0] seq_busy_ticks;
  fault_e      seq_fault;
  logic [7:0]  lim_retry;
  logic [31:0] lim_timeout;

  sfcs_out_t   expected_steps[$];
  sfcs_out_t   want_r;
  sfcs_out_t   got_r;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned errors;
  int unsigned items_sent;
  int unsigned starts_taken;
  int unsigned done_ok;
  int unsigned done_wel;
  int unsigned done_timeout;
  int unsigned stall_cycles;

  function automatic void seq_go_idle();
    seq_busy_ticks = '0;
    seq_retries    = '0;
    seq_op         = OP_NONE;
    seq_phase      = PH_IDLE;
  endfunction

  function automatic sfcs_out_t sequencer_step(sfcs_in_t it);
    sfcs_out_t r;
    r = '0;
    if (it.opcode != OP_NONE) begin
      if (seq_phase == PH_IDLE) begin
        r.accepted     = 1'b1;
        seq_op         = op_e'(it.opcode);
        seq_addr       = it.flash_addr;
        seq_len        = (it.opcode == OP_ERASE) ? 16'd0 : it.byte_count;
        seq_retries    = '0;
        seq_busy_ticks = '0;
        seq_fault      = FLT_NONE;
        seq_phase      = (it.opcode == OP_READ) ? PH_CMD : PH_WREN;
      end
    end else begin
      case (seq_phase)
        PH_IDLE: begin
        end
        PH_WREN: begin
          r.command      = CMD_WREN;
          seq_busy_ticks = '0;
          seq_phase      = PH_CHECK;
        end
        PH_CHECK: begin
          r.command = CMD_RDSR;
          if (it.status_byte[StatusWelBit]) begin
            seq_busy_ticks = '0;
            seq_phase      = PH_CMD;
          end else begin
            if (seq_retries != 8'hff) seq_retries = seq_retries + 8'd1;
            if (seq_retries >= lim_retry) begin
              seq_fault = FLT_WEL;
              seq_phase = PH_ERROR;
            end else begin
              seq_phase = PH_WREN;
            end
          end
        end
        PH_CMD: begin
          case (seq_op)
            OP_READ: begin
              r.command = CMD_READ;
              seq_phase = PH_READING;
            end
            OP_PROG, OP_ERASE: begin
              r.command      = (seq_op == OP_PROG) ? CMD_PROGRAM : CMD_ERASE;
              seq_busy_ticks = '0;
              seq_phase      = PH_WAITBUSY;
            end
            default: seq_go_idle();
          endcase
          if (r.command != CMD_NONE) begin
            r.cmd_addr = seq_addr;
            r.cmd_len  = seq_len;
          end
        end
        PH_READING: begin
          r.done_res = 1'b1;
          r.success  = 1'b1;
          seq_phase  = PH_IDLE;
        end
        PH_WAITBUSY: begin
          r.command = CMD_RDSR;
          if (!it.status_byte[StatusBusyBit]) begin
            r.done_res = 1'b1;
            r.success  = 1'b1;
            seq_phase  = PH_IDLE;
          end else begin
            if (seq_busy_ticks != 32'hffff_ffff) seq_busy_ticks = seq_busy_ticks + 32'd1;
            if (seq_busy_ticks >= lim_timeout) begin
              seq_fault = FLT_TIMEOUT;
              seq_phase = PH_ERROR;
            end
          end
        end
        PH_ERROR: begin
          r.done_res = 1'b1;
          r.fault    = seq_fault;
          seq_go_idle();
        end
        default: seq_go_idle();
      endcase
    end
    r.phase = seq_phase;
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    errors++;
    if (errors <= MaxReports) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [23:0] got,
                             input logic [23:0] want);
    if (got !== want) note_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  // Check every result item against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_steps.size() == 0) begin
        note_mismatch("result item with nothing outstanding");
      end else begin
        want_r = expected_steps.pop_front();
        got_r  = out_data_o;
        check_field("accepted", 24'(got_r.accepted), 24'(want_r.accepted));
        check_field("command",  24'(got_r.command),  24'(want_r.command));
        check_field("cmd_addr", got_r.cmd_addr,      want_r.cmd_addr);
        check_field("cmd_len",  24'(got_r.cmd_len),  24'(want_r.cmd_len));
        check_field("done_res", 24'(got_r.done_res), 24'(want_r.done_res));
        check_field("success",  24'(got_r.success),  24'(want_r.success));
        check_field("fault",    24'(got_r.fault),    24'(want_r.fault));
        check_field("phase",    24'(got_r.phase),    24'(want_r.phase));
        if (want_r.accepted) starts_taken++;
        if (want_r.done_res) begin
          if (want_r.success) done_ok++;
          else if (want_r.fault == FLT_WEL) done_wel++;
          else done_timeout++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // End the run if nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WatchdogLimit) begin
      $display("[%0t] watchdog: no item moved for %0d cycles", $time, stall_cycles);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_item(input sfcs_in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_steps.push_back(sequencer_step(it));
    items_sent++;
  endtask

  task automatic send_start(input op_e op, input logic [23:0] addr, input logic [15:0] len);
    sfcs_in_t it;
    it.opcode      = op;
    it.flash_addr  = addr;
    it.byte_count  = len;
    it.status_byte = 8'($urandom);
    send_item(it);
  endtask

  task automatic send_tick(input logic [7:0] status);
    sfcs_in_t it;
    it.opcode      = OP_NONE;
    it.flash_addr  = 24'($urandom);
    it.byte_count  = 16'($urandom);
    it.status_byte = status;
    send_item(it);
  endtask

  // Drop valid, wait until every outstanding result has been taken, then settle
  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (expected_steps.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    quiesce();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == REG_RETRY_LIMIT) lim_retry = value[7:0];
    else lim_timeout = value;
  endtask

  // Start an operation and tick it back to idle: the first `misses` latch checks
  // see no write enable, the first `busies` busy polls see the flash busy
  task automatic run_operation(input op_e op, input int misses, input int busies);
    logic [7:0] status;
    send_start(op, 24'($urandom), 16'($urandom));
    while (seq_phase != PH_IDLE) begin
      status = 8'($urandom);
      if (seq_phase == PH_CHECK) begin
        status[StatusWelBit] = (misses <= 0);
        misses--;
      end else if (seq_phase == PH_WAITBUSY) begin
        status[StatusBusyBit] = (busies > 0);
        busies--;
      end
      send_tick(status);
    end
  endtask

  task automatic test_directed();
    send_tick(8'hff);                             // tick while idle
    send_start(OP_READ, 24'hff_ffff, 16'hffff);
    send_start(OP_ERASE, 24'h12_3456, 16'h0001);  // ignored while busy
    send_tick(8'h00);
    send_tick(8'hff);
    send_start(OP_PROG, 24'h00_0000, 16'h0000);
    send_tick(8'h00);
    send_tick(8'h02);
    send_start(OP_READ, 24'h55_5555, 16'haaaa);   // ignored while busy
    send_tick(8'h00);
    send_tick(8'h01);
    send_tick(8'hfe);
    send_start(OP_ERASE, 24'ha5_a5a5, 16'hffff);  // erase saves no length
    send_tick(8'h00);
    send_tick(8'h00);
    send_tick(8'h00);
    send_tick(8'hfd);
    send_tick(8'h00);
    send_tick(8'h01);                             // third miss: write enable fault
    send_tick(8'hff);
    send_tick(8'hff);
    send_start(OP_READ, 24'h00_0000, 16'h0000);
    send_tick(8'hff);
    send_tick(8'h00);
  endtask

  task automatic test_retry_limits();
    write_reg(REG_RETRY_LIMIT, 32'd0);
    run_operation(OP_PROG, 1, 0);
    write_reg(REG_RETRY_LIMIT, 32'd1);
    run_operation(OP_ERASE, 1, 0);
    run_operation(OP_PROG, 0, 1);
    write_reg(REG_RETRY_LIMIT, 32'd2);
    run_operation(OP_ERASE, 1, 2);
    run_operation(OP_PROG, 2, 0);
    write_reg(REG_RETRY_LIMIT, 32'd255);
    run_operation(OP_PROG, 254, 1);
    run_operation(OP_ERASE, 255, 0);
  endtask

  task automatic test_busy_timeout();
    write_reg(REG_RETRY_LIMIT, 32'd3);
    write_reg(REG_TIMEOUT_LIMIT, 32'd0);
    run_operation(OP_PROG, 0, 3);
    write_reg(REG_TIMEOUT_LIMIT, 32'd1);
    run_operation(OP_ERASE, 0, 3);
    run_operation(OP_PROG, 0, 0);
    write_reg(REG_TIMEOUT_LIMIT, 32'd7);
    run_operation(OP_PROG, 1, 6);
    run_operation(OP_ERASE, 0, 7);
    write_reg(REG_TIMEOUT_LIMIT, 32'hffff_ffff);
    run_operation(OP_ERASE, 2, 40);
  endtask

  // Mostly well-formed traffic: starts when idle, ticks while busy, some noise
  function automatic sfcs_in_t make_random_item();
    sfcs_in_t it;
    it.flash_addr  = 24'($urandom);
    it.byte_count  = 16'($urandom);
    it.status_byte = 8'($urandom);
    it.status_byte[StatusWelBit]  = ($urandom_range(99) < 65);
    it.status_byte[StatusBusyBit] = ($urandom_range(99) < 70);
    if ($urandom_range(99) < 5) it.opcode = 2'($urandom);
    else if (seq_phase == PH_IDLE)
      it.opcode = ($urandom_range(99) < 80) ? 2'($urandom_range(1, 3)) : OP_NONE;
    else it.opcode = ($urandom_range(99) < 8) ? 2'($urandom_range(1, 3)) : OP_NONE;
    return it;
  endfunction

  task automatic test_random();
    for (int seg = 0; seg < 3; seg++) begin
      write_reg(REG_RETRY_LIMIT, (seg == 0) ? 32'd2 : 32'($urandom_range(1, 6)));
      write_reg(REG_TIMEOUT_LIMIT, (seg == 0) ? 32'd3 : 32'($urandom_range(1, 20)));
      send_idle_pct = (seg == 0) ? 14 : (seg == 1) ? 85 : 0;
      recv_idle_pct = (seg == 0) ? 85 : (seg == 1) ? 14 : 0;
      repeat (RandomItems / 3) send_item(make_random_item());
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    out_ready_i   = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_RETRY_LIMIT;
    cfg_wdata_i   = '0;
    stall_cycles  = 0;
    errors        = 0;
    items_sent    = 0;
    starts_taken  = 0;
    done_ok       = 0;
    done_wel      = 0;
    done_timeout  = 0;
    seq_go_idle();
    seq_addr      = '0;
    seq_len       = '0;
    seq_fault     = FLT_NONE;
    lim_retry     = RetryLimitRst;
    lim_timeout   = TimeoutLimitRst;
    send_idle_pct = 14;
    recv_idle_pct = 85;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_retry_limits();
    test_busy_timeout();
    test_random();
    quiesce();

    $display("Sent %0d items, %0d starts taken", items_sent, starts_taken);
    $display("Finished %0d well, %0d on write enable, %0d on timeout",
             done_ok, done_wel, done_timeout);
    $display("Retry limit 0/1/2/255, timeout 0/1/7/max and random limits; %0d mismatches",
             errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
sv/sfcs_pkg.sv
sv/sfcs_in_stage.sv
sv/sfcs_core.sv
sv/sfcs_out_stage.sv
sv/spi_flash_command_sequencer.sv
verif/testbench.sv
